FILE: hdl/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared constants, codes and the CRC-8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fr_pkg;

    // Frame geometry
    localparam int MAX_FRAME_DEF = 64;
    localparam int MIN_FRAME     = 4;
    localparam int LEN_BIAS      = 2;
    localparam int QUEUE_DEPTH   = 4;

    // Configuration
    localparam logic [7:0] CRC_POLY_RESET = 8'hD5;
    localparam logic [0:0] REG_CRC_POLY   = 1'b0;

    // Kind of a queued byte, decided by the front end
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_STORE   = 2'd0;   // header byte, store only
    localparam kind_t KIND_CRC     = 2'd1;   // store and fold into CRC
    localparam kind_t KIND_END     = 2'd2;   // last byte of a frame, check CRC
    localparam kind_t KIND_LEN_ERR = 2'd3;   // bad length, drop frame

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_GOOD    = 2'd0;
    localparam status_t STATUS_CRC_ERR = 2'd1;
    localparam status_t STATUS_LEN_ERR = 2'd2;

    // MSB-first CRC-8, one byte, implicit top bit of the polynomial
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/crc8fr_front.sv
// ----------------------------------------------------------------------------
// crc8fr_front
// Accepts received bytes, tracks frame position and length, tags each byte
// with its kind and pushes it to the queue. Holds the polynomial register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_front #(
    parameter int MAX_FRAME = crc8fr_pkg::MAX_FRAME_DEF,
    parameter int PW        = $clog2(MAX_FRAME),
    parameter int EW        = 18 + PW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // byte input
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    rx_byte,
    // config port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    // queue write side
    input  wire logic          q_full,
    output logic               q_push,
    output logic [EW-1:0]      q_data
);

    localparam int FW = $clog2(MAX_FRAME + 1);

    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] exp_reg,  exp_next;
    logic [7:0]    poly_reg;

    logic [FW-1:0]           pos_plus1;
    logic [8:0]              len_full;
    logic                    len_ok;
    crc8fr_pkg::kind_t       kind;

    // Polynomial register, written on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_reg <= crc8fr_pkg::CRC_POLY_RESET;
        else if (psel && penable && pwrite && paddr[2] == crc8fr_pkg::REG_CRC_POLY)
            poly_reg <= pwdata[7:0];
    end

    assign prdata = (paddr[2] == crc8fr_pkg::REG_CRC_POLY) ? {24'd0, poly_reg} : 32'd0;

    // Handshake
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Classification
    assign pos_plus1 = fill_reg + FW'(1);
    assign len_full  = {1'b0, rx_byte} + 9'(crc8fr_pkg::LEN_BIAS);
    assign len_ok    = (len_full >= 9'(crc8fr_pkg::MIN_FRAME)) &&
                       (len_full <= 9'(MAX_FRAME));

    always_comb
    begin
        fill_next = pos_plus1;
        exp_next  = exp_reg;
        kind      = crc8fr_pkg::KIND_STORE;
        if (fill_reg == '0) begin
            kind = crc8fr_pkg::KIND_STORE;
        end else if (fill_reg == FW'(1)) begin
            if (len_ok) begin
                kind     = crc8fr_pkg::KIND_STORE;
                exp_next = FW'(len_full);
            end else begin
                kind      = crc8fr_pkg::KIND_LEN_ERR;
                fill_next = '0;
                exp_next  = '0;
            end
        end else if (pos_plus1 == exp_reg) begin
            kind      = crc8fr_pkg::KIND_END;
            fill_next = '0;
            exp_next  = '0;
        end else begin
            kind = crc8fr_pkg::KIND_CRC;
        end
    end

    assign q_data = {poly_reg, kind, fill_reg[PW-1:0], rx_byte};

    // Frame position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg <= '0;
            exp_reg  <= '0;
        end else if (q_push) begin
            fill_reg <= fill_next;
            exp_reg  <= exp_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/crc8fr_queue.sv
// ----------------------------------------------------------------------------
// crc8fr_queue
// Small FIFO that decouples byte intake from frame checking and replay.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = crc8fr_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg,  count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

FILE: hdl/crc8fr_back.sv
// ----------------------------------------------------------------------------
// crc8fr_back
// Drains the queue: stores bytes, folds the CRC, checks the frame end and
// either reports an error or replays the stored frame through the output.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_back #(
    parameter int MAX_FRAME = crc8fr_pkg::MAX_FRAME_DEF,
    parameter int PW        = $clog2(MAX_FRAME),
    parameter int EW        = 18 + PW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // queue read side
    input  wire logic          q_valid,
    input  wire logic [EW-1:0] q_data,
    output logic               q_pop,
    // result output
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         frame_byte,
    output logic [5:0]         byte_index,
    output logic [1:0]         status,
    output logic               last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // Queue entry fields
    logic [7:0]        ent_byte;
    logic [PW-1:0]     ent_pos;
    crc8fr_pkg::kind_t ent_kind;
    logic [7:0]        ent_poly;

    assign ent_byte = q_data[7:0];
    assign ent_pos  = q_data[PW+7:8];
    assign ent_kind = q_data[PW+9:PW+8];
    assign ent_poly = q_data[PW+17:PW+10];

    logic [1:0]    state_reg,  state_next;
    logic [PW-1:0] k_reg,      k_next;
    logic [PW-1:0] end_reg,    end_next;
    logic [7:0]    crc_reg,    crc_next;
    logic          ovalid_reg, ovalid_next;
    logic [7:0]    obyte_reg,  obyte_next;
    logic [5:0]    oidx_reg,   oidx_next;
    logic [1:0]    ostat_reg,  ostat_next;
    logic          olast_reg,  olast_next;
    logic [7:0]    rd_data_reg;
    logic [7:0]    frame_mem [MAX_FRAME];

    logic slot_free;
    logic mem_we;

    assign slot_free = !ovalid_reg || out_ready;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        end_next    = end_reg;
        crc_next    = crc_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        oidx_next   = oidx_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid) begin
                    case (ent_kind)
                        crc8fr_pkg::KIND_STORE:
                        begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        crc8fr_pkg::KIND_CRC:
                        begin
                            q_pop    = 1'b1;
                            mem_we   = 1'b1;
                            crc_next = crc8fr_pkg::crc8_byte(crc_reg, ent_byte, ent_poly);
                        end
                        crc8fr_pkg::KIND_LEN_ERR:
                        begin
                            if (slot_free) begin
                                q_pop       = 1'b1;
                                crc_next    = '0;
                                ovalid_next = 1'b1;
                                obyte_next  = '0;
                                oidx_next   = '0;
                                ostat_next  = crc8fr_pkg::STATUS_LEN_ERR;
                                olast_next  = 1'b1;
                            end
                        end
                        crc8fr_pkg::KIND_END:
                        begin
                            if (slot_free) begin
                                q_pop    = 1'b1;
                                mem_we   = 1'b1;
                                crc_next = '0;
                                if (crc_reg == ent_byte) begin
                                    state_next = ST_RD;
                                    k_next     = '0;
                                    end_next   = ent_pos;
                                end else begin
                                    ovalid_next = 1'b1;
                                    obyte_next  = '0;
                                    oidx_next   = '0;
                                    ostat_next  = crc8fr_pkg::STATUS_CRC_ERR;
                                    olast_next  = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                // store read is registered; data lands in rd_data_reg
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (slot_free) begin
                    ovalid_next = 1'b1;
                    obyte_next  = rd_data_reg;
                    oidx_next   = 6'(k_reg);
                    ostat_next  = crc8fr_pkg::STATUS_GOOD;
                    olast_next  = (k_reg == end_reg);
                    if (k_reg == end_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + PW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            crc_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            crc_reg    <= crc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        end_reg   <= end_next;
        obyte_reg <= obyte_next;
        oidx_reg  <= oidx_next;
        ostat_reg <= ostat_next;
        olast_reg <= olast_next;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[ent_pos] <= ent_byte;
        rd_data_reg <= frame_mem[k_reg];
    end

    assign out_valid  = ovalid_reg;
    assign frame_byte = obyte_reg;
    assign byte_index = oidx_reg;
    assign status     = ostat_reg;
    assign last       = olast_reg;

endmodule

`default_nettype wire

FILE: hdl/crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// CRC-8 checked frame receiver: collects bytes into frames, checks the
// length and CRC, replays good frames and reports bad ones.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_ready    rx_byte
//   output    out        out_valid/out_ready  frame_byte, byte_index, status, last
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// Intake takes one byte per cycle while the 4-entry queue has room.
// The back end drains one queued byte per cycle outside replay; a good frame
// replays each byte via ST_RD then ST_OUT, set by the registered store read.
// Reset leaves an empty queue and an empty frame; the store is not cleared.
// An output stall holds replay and frame results; the queue keeps taking bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_receiver #(
    parameter int MAX_FRAME = crc8fr_pkg::MAX_FRAME_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // result output
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       frame_byte,
    output logic [5:0]       byte_index,
    output logic [1:0]       status,
    output logic             last,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PW = $clog2(MAX_FRAME);
    localparam int EW = 18 + PW;

    logic          q_full;
    logic          q_push;
    logic [EW-1:0] q_wdata;
    logic          q_pop;
    logic          q_valid;
    logic [EW-1:0] q_rdata;

    assign pready = 1'b1;

    crc8fr_front #(
        .MAX_FRAME (MAX_FRAME),
        .PW        (PW),
        .EW        (EW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    crc8fr_queue #(
        .WIDTH (EW),
        .DEPTH (crc8fr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_data (q_rdata)
    );

    crc8fr_back #(
        .MAX_FRAME (MAX_FRAME),
        .PW        (PW),
        .EW        (EW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .status     (status),
        .last       (last)
    );

endmodule

`default_nettype wire
